// File: src/link_state_database_macros.svh
// Assertion macros for the link-state database RTL.
`ifndef LINK_STATE_DATABASE_MACROS_SVH
`define LINK_STATE_DATABASE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LSDB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsdb check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LSDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsdb check failed");

`endif

// File: src/lsdb_pkg.sv
// Package with the types, codes and widths of the link-state database.
`timescale 1ns / 1ps
`default_nettype none

package lsdb_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam int REQ_W     = 2;
    localparam int SENDER_W  = 32;
    localparam int SEQ_W     = 31;
    localparam int HANDLE_W  = 16;
    localparam int VERDICT_W = 3;

    localparam logic [REQ_W-1:0] REQ_RECEIVE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_FLOOD     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DISCARD   = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SEND_BACK = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL      = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_DONE      = 3'd4;

    // One table entry as it sits in the entry memory.
    typedef struct packed {
        logic                valid;
        logic [SENDER_W-1:0] sender;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

endpackage

`default_nettype wire

// File: src/lsdb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lsdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/link_state_database.sv
// Top level of the link-state database: request sequencer, entry scan and result register.
// Each request item scans the single read port of the entry memory once per entry, comparing
// one entry per cycle, then passes a tail and a decide state that registers the result; the
// decide state waits while a held result is stalled. A new item is taken only when idle.
// Reset: rst_n is asynchronous and active low; afterwards a clearing pass writes every entry
// invalid, one per cycle, and the block stalls its input until that pass is done.
`timescale 1ns / 1ps
`default_nettype none

`include "link_state_database_macros.svh"

module link_state_database #(
    parameter int TABLE_DEPTH = lsdb_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Request channel.
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [lsdb_pkg::REQ_W-1:0]       req_type,
    input  wire logic [lsdb_pkg::SENDER_W-1:0]    origin_id,
    input  wire logic [lsdb_pkg::SEQ_W-1:0]       seq_num,
    input  wire logic [lsdb_pkg::HANDLE_W-1:0]    package_handle,
    // Result channel.
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [lsdb_pkg::VERDICT_W-1:0]   verdict,
    output logic                                  found,
    output logic                                  send_valid,
    output logic      [lsdb_pkg::HANDLE_W-1:0]    send_handle,
    output logic      [lsdb_pkg::SEQ_W-1:0]       stored_seq,
    output logic                                  route_invalidate
);

    import lsdb_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;

    // The request being served.
    logic [REQ_W-1:0]    req_reg;
    logic [SENDER_W-1:0] key_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // What the scan has found so far.
    logic                match_found_reg, match_found_next;
    logic [AW-1:0]       match_idx_reg, match_idx_next;
    logic [SEQ_W-1:0]    match_seq_reg, match_seq_next;
    logic [HANDLE_W-1:0] match_handle_reg, match_handle_next;
    logic                free_found_reg, free_found_next;
    logic [AW-1:0]       free_idx_reg, free_idx_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                 found_reg, found_next;
    logic                 send_valid_reg, send_valid_next;
    logic [HANDLE_W-1:0]  send_handle_reg, send_handle_next;
    logic [SEQ_W-1:0]     stored_seq_reg, stored_seq_next;
    logic                 inv_reg, inv_next;

    // Entry memory ports.
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    entry_t                  wr_entry;
    logic                    rd_en;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                  rd_entry;

    logic in_fire;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign rd_entry = entry_t'(rd_data);

    lsdb_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [AW-1:0] target_idx;

        state_next        = state_reg;
        idx_next          = idx_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        match_seq_next    = match_seq_reg;
        match_handle_next = match_handle_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        out_valid_next    = out_valid_reg;
        out_load          = 1'b0;
        verdict_next      = VERDICT_DONE;
        found_next        = 1'b0;
        send_valid_next   = 1'b0;
        send_handle_next  = '0;
        stored_seq_next   = '0;
        inv_next          = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        wr_entry          = '0;
        rd_en             = 1'b0;
        target_idx        = match_found_reg ? match_idx_reg : free_idx_reg;

        // The compare unit looks at the entry read in the previous cycle.
        // The first matching sender and the first free slot are kept.
        if (cmp_vld_reg)
        begin
            if (rd_entry.valid && (rd_entry.sender == key_reg) && !match_found_reg)
            begin
                match_found_next  = 1'b1;
                match_idx_next    = cmp_idx_reg;
                match_seq_next    = rd_entry.seq;
                match_handle_next = rd_entry.handle;
            end
            if (!rd_entry.valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_entry = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en        = 1'b1;
                cmp_vld_next = 1'b1;
                cmp_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_TAIL:
            begin
                // The last entry is compared in this cycle.
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    found_next     = match_found_reg;
                    case (req_reg)
                        REQ_RECEIVE:
                        begin
                            if (match_found_reg && (seq_reg == match_seq_reg))
                            begin
                                verdict_next    = VERDICT_DISCARD;
                                stored_seq_next = match_seq_reg;
                            end
                            else if (match_found_reg && (seq_reg < match_seq_reg))
                            begin
                                verdict_next     = VERDICT_SEND_BACK;
                                send_valid_next  = 1'b1;
                                send_handle_next = match_handle_reg;
                                stored_seq_next  = match_seq_reg;
                            end
                            else if (!match_found_reg && !free_found_reg)
                            begin
                                verdict_next = VERDICT_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = target_idx;
                                wr_entry.valid   = 1'b1;
                                wr_entry.sender  = key_reg;
                                wr_entry.seq     = seq_reg;
                                wr_entry.handle  = handle_reg;
                                verdict_next     = VERDICT_FLOOD;
                                send_valid_next  = 1'b1;
                                send_handle_next = handle_reg;
                                stored_seq_next  = seq_reg;
                                inv_next         = 1'b1;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (match_found_reg)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = match_idx_reg;
                                wr_entry = '0;
                                inv_next = 1'b1;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (match_found_reg)
                            begin
                                send_valid_next  = 1'b1;
                                send_handle_next = match_handle_reg;
                                stored_seq_next  = match_seq_reg;
                            end
                        end
                        default:
                        begin
                            // An unused request type changes nothing and reports nothing.
                            found_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            idx_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cmp_vld_reg     <= cmp_vld_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg      <= cmp_idx_next;
        match_idx_reg    <= match_idx_next;
        match_seq_reg    <= match_seq_next;
        match_handle_reg <= match_handle_next;
        free_idx_reg     <= free_idx_next;
        if (in_fire)
        begin
            req_reg    <= req_type;
            key_reg    <= origin_id;
            seq_reg    <= seq_num;
            handle_reg <= package_handle;
        end
        if (out_load)
        begin
            verdict_reg     <= verdict_next;
            found_reg       <= found_next;
            send_valid_reg  <= send_valid_next;
            send_handle_reg <= send_handle_next;
            stored_seq_reg  <= stored_seq_next;
            inv_reg         <= inv_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign verdict          = verdict_reg;
    assign found            = found_reg;
    assign send_valid       = send_valid_reg;
    assign send_handle      = send_handle_reg;
    assign stored_seq       = stored_seq_reg;
    assign route_invalidate = inv_reg;

    // A flooded advertisement always changes the table and carries its handle.
    `LSDB_ASSERT_SAME(a_flood_invalidates, out_valid && (verdict == VERDICT_FLOOD), send_valid && route_invalidate)
    // A dropped advertisement for a full table never claims an entry or a change.
    `LSDB_ASSERT_SAME(a_full_no_change, out_valid && (verdict == VERDICT_FULL), !found && !route_invalidate && !send_valid)
    // An accepted request always starts a scan of the table.
    `LSDB_ASSERT_NEXT(a_accept_scans, in_fire, state_reg == S_SCAN)
    // The entry memory is written only by the clearing pass or when a request is decided.
    `LSDB_ASSERT_SAME(a_write_states, wr_en, (state_reg == S_CLEAR) || (state_reg == S_DECIDE))

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the link-state database: requests are driven, results are predicted and compared.
`timescale 1ns / 1ps

module tb;
    import lsdb_pkg::*;

    // The block is built at its default depth, and the testbench predictor tracks the same table size.
    localparam int DEPTH = TABLE_DEPTH_DEFAULT;

    // The final wait leaves room for a late or stray result.
    localparam int DRAIN_CYCLES = DEPTH + 20;

    // This is the length of the long receiver hold-off. It is long enough for the block to
    // fill up and stall its own input while the sender keeps offering items.
    localparam int HOLD_CYCLES = 1200;

    // The block ignores this request code, but it still answers with a result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    // The random traffic draws most senders from a pool that is a bit larger than the table.
    // With the mix of receives and deletes used below, the table hovers near full.
    localparam int POOL_SIZE = 80;

    // These are the fields of one result item as the block should produce it.
    typedef struct {
        logic [VERDICT_W-1:0] verdict;
        logic                 found;
        logic                 send_valid;
        logic [HANDLE_W-1:0]  send_handle;
        logic [SEQ_W-1:0]     stored_seq;
        logic                 route_invalidate;
    } lsdb_answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type;
    logic [SENDER_W-1:0]  origin_id;
    logic [SEQ_W-1:0]     seq_num;
    logic [HANDLE_W-1:0]  package_handle;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [VERDICT_W-1:0] verdict;
    logic                 found;
    logic                 send_valid;
    logic [HANDLE_W-1:0]  send_handle;
    logic [SEQ_W-1:0]     stored_seq;
    logic                 route_invalidate;

    // This is the testbench's own copy of the advertisement table. It is updated as each
    // request item is accepted, so it always reflects every accepted request in order.
    bit                   db_valid  [DEPTH];
    logic [SENDER_W-1:0]  db_sender [DEPTH];
    logic [SEQ_W-1:0]     db_seq    [DEPTH];
    logic [HANDLE_W-1:0]  db_handle [DEPTH];

    lsdb_answer_t         expected_answers[$];
    logic [SENDER_W-1:0]  key_pool[POOL_SIZE];
    int                   error_count = 0;

    // The idling levels are given in percent and are set by each test phase.
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;

    // A test raises hold_requests. The receiver process serves each request by counting out a
    // hold-off of its own.
    int                   hold_requests = 0;
    int                   holds_served = 0;
    int                   hold_left = 0;

    link_state_database #(.TABLE_DEPTH(DEPTH)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A stuck handshake must not hang the run. A correct run finishes in well under a
    // millisecond of simulated time.
    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Only valid entries take part in the search. At most one entry can match a sender.
    function automatic int find_sender(logic [SENDER_W-1:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (db_valid[i] && db_sender[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < DEPTH; i++)
            if (!db_valid[i])
                return i;
        return -1;
    endfunction

    // This function applies one request to the table copy and returns the result it should produce.
    function automatic lsdb_answer_t apply_request(logic [REQ_W-1:0] kind,
                                                   logic [SENDER_W-1:0] key,
                                                   logic [SEQ_W-1:0] seq,
                                                   logic [HANDLE_W-1:0] handle);
        lsdb_answer_t ans;
        int           slot;
        slot = find_sender(key);
        ans.verdict = VERDICT_DONE;
        ans.found = (slot >= 0);
        ans.send_valid = 1'b0;
        ans.send_handle = '0;
        ans.stored_seq = '0;
        ans.route_invalidate = 1'b0;
        case (kind)
            REQ_RECEIVE:
            begin
                if (slot >= 0 && seq == db_seq[slot])
                begin
                    // A copy of the advertisement that is already held is dropped.
                    ans.verdict = VERDICT_DISCARD;
                    ans.stored_seq = db_seq[slot];
                end
                else if (slot >= 0 && seq < db_seq[slot])
                begin
                    // A stale advertisement is answered with the newer copy that is held.
                    ans.verdict = VERDICT_SEND_BACK;
                    ans.send_valid = 1'b1;
                    ans.send_handle = db_handle[slot];
                    ans.stored_seq = db_seq[slot];
                end
                else
                begin
                    // A newer advertisement replaces the entry in place. An unknown sender
                    // takes the lowest free slot.
                    if (slot < 0)
                        slot = first_free_slot();
                    if (slot < 0)
                        ans.verdict = VERDICT_FULL;
                    else
                    begin
                        db_valid[slot] = 1'b1;
                        db_sender[slot] = key;
                        db_seq[slot] = seq;
                        db_handle[slot] = handle;
                        ans.verdict = VERDICT_FLOOD;
                        ans.send_valid = 1'b1;
                        ans.send_handle = handle;
                        ans.stored_seq = seq;
                        ans.route_invalidate = 1'b1;
                    end
                end
            end
            REQ_DELETE:
            begin
                if (slot >= 0)
                begin
                    db_valid[slot] = 1'b0;
                    ans.route_invalidate = 1'b1;
                end
            end
            REQ_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    ans.send_valid = 1'b1;
                    ans.send_handle = db_handle[slot];
                    ans.stored_seq = db_seq[slot];
                end
            end
            default:
            begin
                // An unused request code reports nothing, not even a match.
                ans.found = 1'b0;
            end
        endcase
        return ans;
    endfunction

    // This function picks a sequence number for a sender. For a known sender it is mostly
    // equal to, below or just above the held sequence, so that every receive outcome keeps
    // coming up. Otherwise it is a fresh value.
    function automatic logic [SEQ_W-1:0] next_sequence(logic [SENDER_W-1:0] key);
        int               slot;
        logic [SEQ_W-1:0] held;
        slot = find_sender(key);
        if (slot < 0 || $urandom_range(9) >= 8)
            return ($urandom_range(3) == 0) ? SEQ_W'($urandom_range(15)) : SEQ_W'($urandom);
        held = db_seq[slot];
        case ($urandom_range(3))
            0: return held;
            1: return (held == '0) ? held : SEQ_W'($urandom_range(held - 1));
            default: return (held > SEQ_MAX - 4) ? SEQ_MAX : held + SEQ_W'($urandom_range(3, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------------------

    // This task offers one request item and holds it until the block takes it. Valid stays
    // high after acceptance. It is lowered only by an idle cycle of the next call or by the
    // drain, so it never drops and rises in the same time step.
    task automatic send_item(logic [REQ_W-1:0] kind, logic [SENDER_W-1:0] key,
                             logic [SEQ_W-1:0] seq, logic [HANDLE_W-1:0] handle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        origin_id <= key;
        seq_num <= seq;
        package_handle <= handle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_answers.push_back(apply_request(kind, key, seq, handle));
    endtask

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------------------

    // Stall is driven with a nonblocking update at each clock edge. A requested hold-off overrides the random level.
    always @(posedge clk)
    begin : receiver_stall
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // A result is taken at an edge where it is valid and not stalled. All values are read
    // before this edge's updates take effect.
    always @(posedge clk)
    begin : check_results
        lsdb_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none outstanding, expected nothing, actual verdict %0d",
                         $time, verdict);
            end
            else
            begin
                want = expected_answers.pop_front();
                compare_field("verdict", want.verdict, verdict);
                compare_field("found", want.found, found);
                compare_field("send_valid", want.send_valid, send_valid);
                compare_field("send_handle", want.send_handle, send_handle);
                compare_field("stored_seq", want.stored_seq, stored_seq);
                compare_field("route_invalidate", want.route_invalidate, route_invalidate);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // This test covers every request kind and each non-full receive outcome. The field values
    // drive every bit both ways. The test also shows that the sequence compare is unsigned
    // across the top bit, and that the unused code stays silent even for a known sender.
    task automatic test_basic_requests();
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(REQ_LOOKUP,  32'h0000_0000, 31'h0000_0000, 16'h0000);
        send_item(REQ_DELETE,  32'h0000_0000, 31'h7FFF_FFFF, 16'hFFFF);
        send_item(REQ_RECEIVE, 32'h0000_0000, 31'h0000_0000, 16'h0000);
        send_item(REQ_RECEIVE, 32'h0000_0000, 31'h0000_0000, 16'hFFFF);
        send_item(REQ_RECEIVE, 32'h0000_0000, 31'h7FFF_FFFF, 16'hFFFF);
        send_item(REQ_RECEIVE, 32'h0000_0000, 31'h3FFF_FFFF, 16'h1234);
        send_item(REQ_LOOKUP,  32'h0000_0000, 31'h0000_0000, 16'h0000);
        send_item(REQ_RECEIVE, 32'hFFFF_FFFF, 31'h3FFF_FFFF, 16'h5555);
        send_item(REQ_RECEIVE, 32'hFFFF_FFFF, 31'h4000_0000, 16'hAAAA);
        send_item(REQ_RECEIVE, 32'hFFFF_FFFF, 31'h3FFF_FFFF, 16'h0F0F);
        send_item(REQ_UNUSED,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
        send_item(REQ_UNUSED,  32'h1234_5678, 31'h0000_0000, 16'h0000);
        send_item(REQ_LOOKUP,  32'hFFFF_FFFF, 31'h0000_0000, 16'h0000);
        send_item(REQ_DELETE,  32'h0000_0000, 31'h0000_0000, 16'h0000);
        send_item(REQ_DELETE,  32'h0000_0000, 31'h0000_0000, 16'h0000);
        send_item(REQ_LOOKUP,  32'h0000_0000, 31'h0000_0000, 16'h0000);
        // The sender that was just removed goes back into the lowest free slot.
        send_item(REQ_RECEIVE, 32'h0000_0000, 31'h0000_0001, 16'h0001);
        send_item(REQ_RECEIVE, 32'hAAAA_AAAA, 31'h5555_5555, 16'h5AA5);
        send_item(REQ_RECEIVE, 32'h5555_5555, 31'h2AAA_AAAA, 16'hA55A);
        send_item(REQ_RECEIVE, 32'h5555_5555, 31'h2AAA_AAAB, 16'hC33C);
        send_item(REQ_DELETE,  32'hFFFF_FFFF, 31'h0000_0000, 16'h0000);
        send_item(REQ_LOOKUP,  32'hAAAA_AAAA, 31'h0000_0000, 16'h0000);
        wait_for_answers();
    endtask

    // This test fills every slot with new senders, then checks the behavior of a full table.
    // New senders are dropped there, while known senders still update, answer lookups and
    // can be deleted. The table is emptied at the end so that the random phases start clean.
    task automatic test_table_full();
        logic [SENDER_W-1:0] key;
        send_idle_pct = 20;
        stall_pct = 20;
        while (first_free_slot() >= 0)
        begin
            key = $urandom;
            if (find_sender(key) < 0)
                send_item(REQ_RECEIVE, key, SEQ_W'($urandom), HANDLE_W'($urandom));
        end
        repeat (3)
            send_item(REQ_RECEIVE, $urandom, SEQ_W'($urandom), HANDLE_W'($urandom));
        repeat (4)
        begin
            key = db_sender[$urandom_range(DEPTH - 1)];
            send_item(REQ_RECEIVE, key, next_sequence(key), HANDLE_W'($urandom));
        end
        send_item(REQ_LOOKUP, db_sender[DEPTH - 1], '0, '0);
        send_item(REQ_DELETE, db_sender[$urandom_range(DEPTH - 1)], '0, '0);
        send_item(REQ_RECEIVE, $urandom, SEQ_W'($urandom), HANDLE_W'($urandom));
        send_item(REQ_RECEIVE, $urandom, SEQ_W'($urandom), HANDLE_W'($urandom));
        for (int i = 0; i < DEPTH; i++)
            if (db_valid[i])
                send_item(REQ_DELETE, db_sender[i], SEQ_W'($urandom), HANDLE_W'($urandom));
        wait_for_answers();
    endtask

    // Random traffic is mostly receives on pooled senders, which repeat, so the outcomes
    // cover updates, duplicates and stale copies. Deletes and lookups are mixed in. A few
    // requests use unknown senders or the unused code.
    task automatic test_random_traffic(int count, int idle_pct, int stall_level);
        logic [REQ_W-1:0]    kind;
        logic [SENDER_W-1:0] key;
        int                  pick;
        send_idle_pct = idle_pct;
        stall_pct = stall_level;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            kind = (pick < 58) ? REQ_RECEIVE :
                   (pick < 74) ? REQ_DELETE  :
                   (pick < 96) ? REQ_LOOKUP  : REQ_UNUSED;
            key = ($urandom_range(19) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
            send_item(kind, key, next_sequence(key), HANDLE_W'($urandom));
        end
    endtask

    // This test makes the receiver hold off for a long stretch while requests arrive back to
    // back. The results back up inside the block until it stalls its request input.
    task automatic test_output_backpressure();
        hold_requests++;
        test_random_traffic(24, 0, 0);
        wait_for_answers();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_RECEIVE;
        origin_id = '0;
        seq_num = '0;
        package_handle = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // After reset, the block runs its clearing pass with its input stalled.
        // The first request simply waits for the block to accept it.
        test_basic_requests();
        test_table_full();
        test_random_traffic(170, 0, 0);
        test_random_traffic(170, 88, 0);
        test_random_traffic(170, 0, 88);
        test_random_traffic(170, 26, 26);
        test_output_backpressure();

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
